@@ rtl/two_voice_sample_mixer_unit_macros.svh @@
// Assertion macros for the two-voice sample mixer.
// Used by two_voice_sample_mixer_unit.sv; expects clk_i and rst_ni in scope.
`ifndef TWO_VOICE_SAMPLE_MIXER_UNIT_MACROS_SVH
`define TWO_VOICE_SAMPLE_MIXER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define TVSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TVSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TVSM_ASSERT_IMPL(lbl, ante, cons, msg)
`define TVSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/tvsm_pkg.sv @@
// Shared constants, codes and types of the two-voice sample mixer.
// No dependencies; imported by tvsm_mul, two_voice_sample_mixer_unit and the bench.
package tvsm_pkg;

  localparam int STORE_ADDR_BITS = 16;
  localparam int VOICES          = 2;
  localparam int VOICE_BITS      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int STORE_DEPTH     = 1 << STORE_ADDR_BITS;

  localparam int POS_W    = 50;
  localparam int FRAC_W   = 32;
  localparam int IDX_W    = POS_W - FRAC_W;
  localparam int STEP_W   = 40;
  localparam int VOL_W    = 7;
  localparam int ADDR_W   = 16;
  localparam int LEN_W    = 16;
  localparam int LOOP_W   = 8;
  localparam int SAMPLE_W = 8;
  localparam int AUDIO_W  = 16;
  localparam int MIX_W    = AUDIO_W + VOICE_BITS;
  localparam int CFG_W    = 40;
  localparam int CFG_IDX_W = 1;

  // Shared multiplier: signed operand times unsigned operand.
  localparam int OPA_W  = 10;
  localparam int OPB_W  = 8;
  localparam int PROD_W = 18;

  localparam int INTERP_SHIFT = 8;
  localparam int AUDIO_MAX    = 32767;
  localparam int AUDIO_MIN    = -32768;

  localparam logic [STEP_W-1:0]          STEP_RESET  = 40'd1073741824;
  localparam logic [VOL_W-1:0]           VOL_RESET   = 7'd100;
  localparam logic signed [SAMPLE_W:0]   SAMPLE_BIAS = 9'sd128;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_FRAME = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP   = 1'b0,
    REG_VOLUME = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WRAP,
    S_RDA,
    S_RDB,
    S_MUL1,
    S_SUM,
    S_MUL2,
    S_ACC,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic                    en;
    logic signed [OPA_W-1:0] op_a;
    logic [OPB_W-1:0]        op_b;
  } mul_req_t;

endpackage

@@ rtl/two_voice_sample_mixer_unit.sv @@
// Top level of the two-voice sample mixer: store, voice state, sequencer.
// Depends on tvsm_pkg, tvsm_mul and two_voice_sample_mixer_unit_macros.svh.
//
//   channel   direction  handshake                  payload
//   in        sink       in_valid_i / in_stall_o    action, address, sample_byte, voice,
//                                                   sound_length, pass_count, music L/R
//   out       source     out_valid_o / out_stall_i  out_left, out_right, voices_active
//   cfg       sink       cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// Write, start and stop transactions complete in the cycle they are accepted.
// A frame keeps the block busy: a silent voice takes its check state only, a
// playing one the check, two store reads, multiply, sum, multiply, accumulate
// and a wrap state if it wraps, then the output state. The single store read
// port and the shared multiplier set this. Reset clears the sequencer, voice
// on bits and output valid, presets step and volume and leaves the store. A
// stalled output holds only the output state; new input waits during a frame.
`include "two_voice_sample_mixer_unit_macros.svh"

module two_voice_sample_mixer_unit
  import tvsm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  // input transactions
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [ADDR_W-1:0]          address_i,
  input  logic [SAMPLE_W-1:0]        sample_byte_i,
  input  logic                       voice_i,
  input  logic [LEN_W-1:0]           sound_length_i,
  input  logic [LOOP_W-1:0]          pass_count_i,
  input  logic signed [AUDIO_W-1:0]  music_left_i,
  input  logic signed [AUDIO_W-1:0]  music_right_i,
  // output transactions
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [AUDIO_W-1:0]  out_left_o,
  output logic signed [AUDIO_W-1:0]  out_right_o,
  output logic [1:0]                 voices_active_o
);

  localparam logic signed [MIX_W:0] SUM_MAX = (MIX_W+1)'(AUDIO_MAX);
  localparam logic signed [MIX_W:0] SUM_MIN = (MIX_W+1)'(AUDIO_MIN);

  // Clamp a widened sum back to the audio range.
  function automatic logic signed [AUDIO_W-1:0] sat_audio(input logic signed [MIX_W:0] v);
    logic signed [AUDIO_W-1:0] r;
    if (v > SUM_MAX) begin
      r = AUDIO_W'(SUM_MAX);
    end else if (v < SUM_MIN) begin
      r = AUDIO_W'(SUM_MIN);
    end else begin
      r = AUDIO_W'(v);
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // State
  // ------------------------------------------------------------------
  seq_state_e state_q, state_d;
  logic [VOICE_BITS-1:0] vsel_q;
  logic [VOICES-1:0]     voice_on_q;
  logic [STEP_W-1:0]     step_q;
  logic [VOL_W-1:0]      vol_q;
  logic                  out_valid_q;

  logic [ADDR_W-1:0]     start_q [VOICES];
  logic [LEN_W-1:0]      len_q   [VOICES];
  logic [LOOP_W-1:0]     loops_q [VOICES];
  logic [POS_W-1:0]      pos_q   [VOICES];

  logic signed [AUDIO_W-1:0] music_left_q, music_right_q;
  logic signed [SAMPLE_W:0]  a_q;
  logic signed [SAMPLE_W:0]  s_q;
  logic                      interp_q;
  logic signed [MIX_W-1:0]   mix_q;
  logic signed [AUDIO_W-1:0] out_left_q, out_right_q;
  logic [1:0]                voices_active_q;

  logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // ------------------------------------------------------------------
  // Shared decode
  // ------------------------------------------------------------------
  action_e act_c;
  logic    in_acc;
  logic    slot_free;

  assign act_c      = action_e'(action_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Fields of the voice under work.
  logic                cur_on;
  logic [POS_W-1:0]    cur_pos;
  logic [IDX_W-1:0]    cur_idx;
  logic [LEN_W-1:0]    cur_len;
  logic [LOOP_W-1:0]   cur_loops;
  logic [LOOP_W-1:0]   loops_dec;
  logic                ge_len;
  logic                loops_end;
  logic                last_voice;
  logic                interp_c;

  assign cur_on     = voice_on_q[vsel_q];
  assign cur_pos    = pos_q[vsel_q];
  assign cur_idx    = cur_pos[POS_W-1:FRAC_W];
  assign cur_len    = len_q[vsel_q];
  assign cur_loops  = loops_q[vsel_q];
  assign loops_dec  = cur_loops - LOOP_W'(1);
  assign ge_len     = cur_idx >= IDX_W'(cur_len);
  assign loops_end  = (cur_loops != '0) && (loops_dec == '0);
  assign last_voice = (int'(vsel_q) == VOICES - 1);
  assign interp_c   = ((IDX_W+1)'(cur_idx) + (IDX_W+1)'(1)) < (IDX_W+1)'(cur_len);

  // Store read address: sound start plus sample index (plus one for the second sample), wrapped to the store.
  logic                 rd_second;
  logic [IDX_W:0]       rd_sum;
  logic [STORE_ADDR_BITS-1:0] rd_addr;

  assign rd_sum  = (IDX_W+1)'(start_q[vsel_q]) + (IDX_W+1)'(cur_idx)
                 + (IDX_W+1)'(rd_second);
  assign rd_addr = STORE_ADDR_BITS'(rd_sum);

  // Centered store sample (first, then second) and the interpolation difference.
  logic signed [SAMPLE_W:0] b_c;
  logic signed [OPA_W-1:0]  diff_c;

  assign b_c    = $signed({1'b0, rdata_q}) - SAMPLE_BIAS;
  assign diff_c = OPA_W'(b_c) - OPA_W'(a_q);

  // ------------------------------------------------------------------
  // Shared multiplier
  // ------------------------------------------------------------------
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;

  tvsm_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // ------------------------------------------------------------------
  // Sequencer: outputs
  // ------------------------------------------------------------------
  logic adv_voice;
  logic turn_off;
  logic wrap_en;
  logic loops_en;
  logic acc_en;
  logic load_out;

  always_comb begin
    adv_voice = 1'b0;
    turn_off  = 1'b0;
    wrap_en   = 1'b0;
    loops_en  = 1'b0;
    acc_en    = 1'b0;
    load_out  = 1'b0;
    rd_second = 1'b0;
    mul_req   = '0;
    case (state_q)
      S_CHECK: begin
        if (!cur_on) begin
          adv_voice = 1'b1;
        end else if (ge_len) begin
          // End of sound: count down a pass, then stop or wrap.
          loops_en = (cur_loops != '0);
          if (loops_end) begin
            turn_off  = 1'b1;
            adv_voice = 1'b1;
          end else begin
            wrap_en = 1'b1;
          end
        end
      end
      S_WRAP: begin
        // Still past the end after one wrap: stop.
        if (ge_len) begin
          turn_off  = 1'b1;
          adv_voice = 1'b1;
        end
      end
      S_RDB: begin
        rd_second = 1'b1;
      end
      S_MUL1: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = diff_c;
        mul_req.op_b = cur_pos[FRAC_W-1 -: OPB_W];
      end
      S_MUL2: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = OPA_W'(s_q);
        mul_req.op_b = OPB_W'(vol_q) + OPB_W'(1);
      end
      S_ACC: begin
        acc_en    = 1'b1;
        adv_voice = 1'b1;
      end
      S_DONE: begin
        load_out = slot_free;
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && act_c == ACT_FRAME) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (adv_voice) begin
          state_d = last_voice ? S_DONE : S_CHECK;
        end else if (wrap_en) begin
          state_d = S_WRAP;
        end else begin
          state_d = S_RDA;
        end
      end
      S_WRAP: begin
        if (adv_voice) begin
          state_d = last_voice ? S_DONE : S_CHECK;
        end else begin
          state_d = S_RDA;
        end
      end
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_MUL1;
      S_MUL1: state_d = S_SUM;
      S_SUM:  state_d = S_MUL2;
      S_MUL2: state_d = S_ACC;
      S_ACC:  state_d = last_voice ? S_DONE : S_CHECK;
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vsel_q      <= '0;
      voice_on_q  <= '0;
      step_q      <= STEP_RESET;
      vol_q       <= VOL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Restart the voice walk on each frame, advance past each voice.
      if (in_acc && act_c == ACT_FRAME) begin
        vsel_q <= '0;
      end else if (adv_voice && !last_voice) begin
        vsel_q <= vsel_q + VOICE_BITS'(1);
      end

      if (in_acc && act_c == ACT_START && int'(voice_i) < VOICES) begin
        voice_on_q[VOICE_BITS'(voice_i)] <= 1'b1;
      end else if (in_acc && act_c == ACT_STOP && int'(voice_i) < VOICES) begin
        voice_on_q[VOICE_BITS'(voice_i)] <= 1'b0;
      end else if (turn_off) begin
        voice_on_q[vsel_q] <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_STEP:   step_q <= STEP_W'(cfg_wdata_i);
          REG_VOLUME: vol_q  <= VOL_W'(cfg_wdata_i);
          default: begin
          end
        endcase
      end

      // Hold a result until taken; drop it once the sink takes it.
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Voice state and datapath registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc && act_c == ACT_START && int'(voice_i) < VOICES) begin
      start_q[VOICE_BITS'(voice_i)] <= address_i;
      len_q[VOICE_BITS'(voice_i)]   <= sound_length_i;
      loops_q[VOICE_BITS'(voice_i)] <= pass_count_i;
      pos_q[VOICE_BITS'(voice_i)]   <= '0;
    end else begin
      if (loops_en) begin
        loops_q[vsel_q] <= loops_dec;
      end
      if (wrap_en) begin
        pos_q[vsel_q] <= {cur_idx - IDX_W'(cur_len), cur_pos[FRAC_W-1:0]};
      end else if (acc_en) begin
        pos_q[vsel_q] <= cur_pos + POS_W'(step_q);
      end
    end

    if (in_acc && act_c == ACT_FRAME) begin
      music_left_q  <= music_left_i;
      music_right_q <= music_right_i;
      mix_q         <= '0;
    end else if (acc_en) begin
      mix_q <= mix_q + (MIX_W'(prod) <<< 1);
    end

    if (state_q == S_RDA) begin
      interp_q <= interp_c;
    end
    if (state_q == S_RDB) begin
      a_q <= b_c;
    end
    if (state_q == S_SUM) begin
      s_q <= interp_q ? (a_q + (SAMPLE_W+1)'(prod >>> INTERP_SHIFT)) : a_q;
    end

    if (load_out) begin
      out_left_q      <= sat_audio((MIX_W+1)'(music_left_q) + (MIX_W+1)'(mix_q));
      out_right_q     <= sat_audio((MIX_W+1)'(music_right_q) + (MIX_W+1)'(mix_q));
      voices_active_q <= 2'(voice_on_q);
    end
  end

  // ------------------------------------------------------------------
  // Sample store: one write port, one registered read port
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc && act_c == ACT_WRITE) begin
      store_mem[STORE_ADDR_BITS'(address_i)] <= sample_byte_i;
    end
    rdata_q <= store_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign out_left_o      = out_left_q;
  assign out_right_o     = out_right_q;
  assign voices_active_o = voices_active_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `TVSM_ASSERT_NEXT(a_no_voice_on_while_busy, state_q != S_IDLE, (voice_on_q & ~$past(voice_on_q)) == '0, "voice turned on during a frame")
  `TVSM_ASSERT_NEXT(a_done_loads_result, state_q == S_DONE && slot_free, out_valid_q && state_q == S_IDLE, "frame result not loaded")
  `TVSM_ASSERT_NEXT(a_frame_starts_clean, in_acc && act_c == ACT_FRAME, state_q == S_CHECK && vsel_q == '0 && mix_q == '0, "frame did not start at first voice")
  `TVSM_ASSERT_IMPL(a_walk_in_range, state_q != S_IDLE, int'(vsel_q) < VOICES, "voice select out of range")

endmodule

@@ rtl/tvsm_mul.sv @@
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on tvsm_pkg for operand widths and the request struct.
module tvsm_mul
  import tvsm_pkg::*;
(
  input  logic                     clk_i,
  input  mul_req_t                 req_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;

  assign prod_d = PROD_W'(req_i.op_a) * PROD_W'($signed({1'b0, req_i.op_b}));

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ bench/tb_two_voice_sample_mixer_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for two_voice_sample_mixer_unit.
// Depends on tvsm_pkg and the mixer RTL; keeps its own model of store and voices.

module tb_two_voice_sample_mixer_unit;
  import tvsm_pkg::*;

  localparam int HOLD_CYCLES   = 400;       // long output hold-off
  localparam int SETTLE_CYCLES = 24;        // longer than the slowest frame
  localparam int LIMIT_CYCLES  = 1_000_000;

  // One input transaction, every field present whatever the action.
  typedef struct packed {
    action_e                   act;
    logic [ADDR_W-1:0]         addr;
    logic [SAMPLE_W-1:0]       data;
    logic                      voice;
    logic [LEN_W-1:0]          len;
    logic [LOOP_W-1:0]         loops;
    logic signed [AUDIO_W-1:0] ml;
    logic signed [AUDIO_W-1:0] mr;
  } mixer_item_t;

  typedef struct packed {
    logic signed [AUDIO_W-1:0] left;
    logic signed [AUDIO_W-1:0] right;
    logic [1:0]                active;
  } frame_out_t;

  typedef struct packed {
    bit              on;
    bit [ADDR_W-1:0] start;
    bit [LEN_W-1:0]  len;
    bit [POS_W-1:0]  pos;
    bit [LOOP_W-1:0] loops;
  } voice_t;

  // DUT connections; every input starts at a known value.
  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i   = REG_STEP;
  logic [CFG_W-1:0]          cfg_wdata_i   = '0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                action_i      = ACT_WRITE;
  logic [ADDR_W-1:0]         address_i     = '0;
  logic [SAMPLE_W-1:0]       sample_byte_i = '0;
  logic                      voice_i       = 1'b0;
  logic [LEN_W-1:0]          sound_length_i = '0;
  logic [LOOP_W-1:0]         pass_count_i  = '0;
  logic signed [AUDIO_W-1:0] music_left_i  = '0;
  logic signed [AUDIO_W-1:0] music_right_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i   = 1'b0;
  logic signed [AUDIO_W-1:0] out_left_o;
  logic signed [AUDIO_W-1:0] out_right_o;
  logic [1:0]                voices_active_o;

  // Mirror of the block: sample store, voice state and registers.
  bit [SAMPLE_W-1:0] pcm_mem     [STORE_DEPTH];
  bit                pcm_written [STORE_DEPTH];
  voice_t            voice_st    [VOICES];
  bit [STEP_W-1:0]   step_q = STEP_RESET;
  bit [VOL_W-1:0]    vol_q  = VOL_RESET;

  frame_out_t expected_frames[$];
  int         mismatches  = 0;
  int         items_sent  = 0;
  int         cycle_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;

  // The receiver owns its hold-off counter; a test asks for a hold by toggling.
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  two_voice_sample_mixer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .address_i       (address_i),
    .sample_byte_i   (sample_byte_i),
    .voice_i         (voice_i),
    .sound_length_i  (sound_length_i),
    .pass_count_i    (pass_count_i),
    .music_left_i    (music_left_i),
    .music_right_i   (music_right_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_left_o      (out_left_o),
    .out_right_o     (out_right_o),
    .voices_active_o (voices_active_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Play one frame of a voice: wrap or end it, interpolate, apply the gain and
  // advance its position. Also report which store entries the frame reads, so
  // a dry run on a copy tells which bytes must be written first.
  function automatic int mix_voice(inout voice_t vs, output bit [1:0] taps,
                                   output bit [ADDR_W-1:0] tap_a, tap_b);
    bit [IDX_W-1:0] idx;
    bit [7:0]       frac;
    int             a, b, smp;
    taps  = 2'b00;
    tap_a = '0;
    tap_b = '0;
    if (!vs.on) return 0;
    idx = vs.pos[POS_W-1:FRAC_W];
    if (idx >= IDX_W'(vs.len)) begin
      // a finite pass count spends one pass here; stop on the last one
      if (vs.loops != 0) begin
        vs.loops = vs.loops - LOOP_W'(1);
        if (vs.loops == 0) begin
          vs.on = 1'b0;
          return 0;
        end
      end
      vs.pos = vs.pos - POS_W'({vs.len, 32'd0});
      idx    = vs.pos[POS_W-1:FRAC_W];
      // a step larger than the sound leaves it past the end: drop the voice
      if (idx >= IDX_W'(vs.len)) begin
        vs.on = 1'b0;
        return 0;
      end
    end
    frac     = vs.pos[FRAC_W-1:FRAC_W-8];
    tap_a    = vs.start + idx[ADDR_W-1:0];
    taps[0]  = 1'b1;
    a        = int'(pcm_mem[tap_a]) - 128;
    if (32'(idx) + 1 < 32'(vs.len)) begin
      tap_b   = vs.start + idx[ADDR_W-1:0] + 16'd1;
      taps[1] = 1'b1;
      b       = int'(pcm_mem[tap_b]) - 128;
      // arithmetic shift: rounds toward minus infinity
      smp     = a + (((b - a) * int'(frac)) >>> 8);
    end else begin
      // last sample of the sound: no neighbor to blend with
      smp = a;
    end
    vs.pos = vs.pos + POS_W'(step_q);
    return smp * 2 * (int'(vol_q) + 1);
  endfunction

  function automatic logic signed [AUDIO_W-1:0] clip16(int v);
    if (v > AUDIO_MAX) return AUDIO_W'(AUDIO_MAX);
    if (v < AUDIO_MIN) return AUDIO_W'(AUDIO_MIN);
    return AUDIO_W'(v);
  endfunction

  function automatic frame_out_t predict_frame(logic signed [AUDIO_W-1:0] ml, mr);
    frame_out_t      f;
    int              mix;
    bit [1:0]        taps;
    bit [ADDR_W-1:0] ta, tb;
    mix      = 0;
    f.active = '0;
    for (int k = 0; k < VOICES; k++) begin
      mix += mix_voice(voice_st[k], taps, ta, tb);
      if (voice_st[k].on) f.active[k] = 1'b1;
    end
    f.left  = clip16(int'(ml) + mix);
    f.right = clip16(int'(mr) + mix);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------

  // Fields that the action does not use still carry random values.
  function automatic mixer_item_t rand_item(action_e a);
    mixer_item_t it;
    it.act   = a;
    it.addr  = ADDR_W'($urandom);
    it.data  = SAMPLE_W'($urandom);
    it.voice = 1'($urandom);
    it.len   = LEN_W'($urandom);
    it.loops = LOOP_W'($urandom);
    it.ml    = AUDIO_W'($urandom);
    it.mr    = AUDIO_W'($urandom);
    return it;
  endfunction

  // Offer one transaction, wait for the handshake, then update the model.
  // Called at a rising edge; leaves valid high so back-to-back items need no gap.
  task automatic send_txn(input mixer_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= it.act;
    address_i      <= it.addr;
    sample_byte_i  <= it.data;
    voice_i        <= it.voice;
    sound_length_i <= it.len;
    pass_count_i   <= it.loops;
    music_left_i   <= it.ml;
    music_right_i  <= it.mr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    case (it.act)
      ACT_WRITE: begin
        pcm_mem[it.addr]     = it.data;
        pcm_written[it.addr] = 1'b1;
      end
      ACT_START: voice_st[it.voice] = '{on: 1'b1, start: it.addr, len: it.len,
                                        pos: '0, loops: it.loops};
      ACT_STOP:  voice_st[it.voice].on = 1'b0;
      ACT_FRAME: expected_frames.push_back(predict_frame(it.ml, it.mr));
      default: begin
      end
    endcase
  endtask

  task automatic send_write(bit [ADDR_W-1:0] addr, bit [SAMPLE_W-1:0] data);
    mixer_item_t it;
    it      = rand_item(ACT_WRITE);
    it.addr = addr;
    it.data = data;
    send_txn(it);
  endtask

  task automatic send_start(bit v, bit [ADDR_W-1:0] addr, bit [LEN_W-1:0] len,
                            bit [LOOP_W-1:0] loops);
    mixer_item_t it;
    it       = rand_item(ACT_START);
    it.voice = v;
    it.addr  = addr;
    it.len   = len;
    it.loops = loops;
    send_txn(it);
  endtask

  task automatic send_stop(bit v);
    mixer_item_t it;
    it       = rand_item(ACT_STOP);
    it.voice = v;
    send_txn(it);
  endtask

  // Before a frame, write any store byte the frame is about to read that has
  // never been written; the block's store holds garbage there.
  task automatic send_frame(logic signed [AUDIO_W-1:0] ml, mr);
    mixer_item_t     it;
    voice_t          probe;
    bit [1:0]        taps;
    bit [ADDR_W-1:0] ta, tb;
    int              unused;
    for (int k = 0; k < VOICES; k++) begin
      probe  = voice_st[k];
      unused = mix_voice(probe, taps, ta, tb);
      if (taps[0] && !pcm_written[ta]) send_write(ta, SAMPLE_W'($urandom));
      if (taps[1] && !pcm_written[tb]) send_write(tb, SAMPLE_W'($urandom));
    end
    it    = rand_item(ACT_FRAME);
    it.ml = ml;
    it.mr = mr;
    send_txn(it);
  endtask

  // Drop valid, wait for every frame result, then let the sequencer settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges; only while the block is idle.
  task automatic configure(bit [STEP_W-1:0] step, bit [VOL_W-1:0] vol);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_STEP;
    cfg_wdata_i <= CFG_W'(step);
    @(posedge clk_i);
    cfg_index_i <= REG_VOLUME;
    cfg_wdata_i <= CFG_W'(vol);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    step_q = step;
    vol_q  = vol;
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  function automatic bit [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 78) return LEN_W'($urandom_range(1, 48));
    if (r < 90) return LEN_W'($urandom_range(49, 600));
    return LEN_W'($urandom);
  endfunction

  function automatic bit [LOOP_W-1:0] pick_loops();
    int r;
    r = $urandom_range(99);
    if (r < 35) return '0;
    if (r < 80) return LOOP_W'($urandom_range(1, 4));
    if (r < 90) return 8'hFF;
    return LOOP_W'($urandom);
  endfunction

  // Mostly full-range music, with the rails often enough to hit saturation.
  function automatic logic signed [AUDIO_W-1:0] pick_music();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return AUDIO_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked corners: address wrap of the store, saturation on both rails,
  // negative interpolation rounding, last sample, loop end, zero length,
  // restart, endless looping, the widest sound and the stop action.
  task automatic test_edge_cases();
    configure(40'h00_8000_0000, 7'd127);  // half a sample per frame, unity gain
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_write(16'hFFFF, 8'hFF);
    send_write(16'h0000, 8'h00);
    send_write(16'h0001, 8'h80);
    send_start(1'b0, 16'hFFFF, 16'd3, 8'd2);  // sound straddles the top of the store
    send_start(1'b1, 16'h0000, 16'd0, 8'd0);  // empty sound ends on its first frame
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);         // halfway between 0xFF and 0x00
    repeat (4) send_frame(pick_music(), pick_music());
    send_start(1'b0, 16'hFFFF, 16'd3, 8'd0);  // restart over a playing voice
    repeat (3) send_frame(pick_music(), pick_music());
    send_start(1'b1, 16'h8000, 16'hFFFF, 8'hFF);
    repeat (2) send_frame(16'sh8000, 16'sh8000);
    send_stop(1'b1);
    send_stop(1'b0);
    send_frame(16'sh0000, 16'sh0000);
  endtask

  // Mostly well-formed playback: fill a short sound, start it and run frames,
  // mixed with stray writes, stops and long sounds filled on demand.
  task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct,
                                     bit [STEP_W-1:0] step, bit [VOL_W-1:0] vol);
    int              stop_at;
    int              r;
    bit              v;
    bit [ADDR_W-1:0] base;
    bit [LEN_W-1:0]  len;
    wait_drained();
    configure(step, vol);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if ((!voice_st[0].on && !voice_st[1].on && r < 60) || r < 5) begin
        v    = 1'($urandom);
        base = ADDR_W'($urandom);
        len  = pick_length();
        if (len <= 48) begin
          for (int i = 0; i < int'(len); i++)
            send_write(ADDR_W'(base + i), SAMPLE_W'($urandom));
        end
        send_start(v, base, len, pick_loops());
      end else if (r < 9) begin
        send_stop(1'($urandom));
      end else if (r < 15) begin
        send_write(ADDR_W'($urandom), SAMPLE_W'($urandom));
      end else begin
        send_frame(pick_music(), pick_music());
      end
    end
  endtask

  // Hold the output off for a long stretch while frames keep coming, so the
  // block backs up into its input; then pause the sender until all is back.
  task automatic test_output_hold();
    wait_drained();
    configure(40'h01_0000_0000, 7'd64);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_start(1'b0, ADDR_W'($urandom), 16'd40, 8'd0);
    hold_req <= ~hold_req;
    repeat (30) send_frame(pick_music(), pick_music());
    wait_drained();
    repeat (10) send_frame(pick_music(), pick_music());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result check
  // ---------------------------------------------------------------------------

  task automatic check_frame();
    frame_out_t want;
    if (expected_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected frame: L=%0d R=%0d active=%b",
                 out_left_o, out_right_o, voices_active_o);
      return;
    end
    want = expected_frames.pop_front();
    if (out_left_o !== want.left || out_right_o !== want.right ||
        voices_active_o !== want.active) begin
      mismatches++;
      if (mismatches <= 10)
        $display("frame mismatch: expected L=%0d R=%0d active=%b, got L=%0d R=%0d active=%b",
                 want.left, want.right, want.active,
                 out_left_o, out_right_o, voices_active_o);
    end
  endtask

  // Sample the output handshake at the edge, then pick the next stall value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_frame();
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    // sender idles often, receiver idles more
    test_random_traffic(225, 36, 78, 40'h01_0000_0000, 7'd127);
    test_random_traffic(225, 36, 78, 40'({$urandom_range(1), $urandom}),
                        7'($urandom));
    // the other way round, with the step and gain at their extremes
    test_random_traffic(225, 78, 36, 40'hFF_FFFF_FFFF, 7'd0);
    test_random_traffic(225, 78, 36, 40'h00_0000_0000, 7'd127);
    // full rate on both sides
    test_random_traffic(225, 0, 0, 40'h00_4000_0000, 7'($urandom));
    test_random_traffic(225, 0, 0, 40'({$urandom_range(3), $urandom}),
                        7'($urandom));
    test_output_hold();

    wait_drained();
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ two_voice_sample_mixer_unit.f @@
+incdir+rtl
rtl/tvsm_pkg.sv
rtl/tvsm_mul.sv
rtl/two_voice_sample_mixer_unit.sv
bench/tb_two_voice_sample_mixer_unit.sv
